/* hw/rtl/rbb_pkg.sv */
// Shared types and constants of the RGB 3x3 box blur.
package rbb_pkg;

  // Pixel and channel widths
  localparam int CH_W    = 8;
  localparam int PX_W    = 3 * CH_W;
  localparam int LANES   = 3;
  localparam int TAPS    = 9;
  localparam int CENTER  = 4;

  // Sum of nine channels plus the rounding term fits in 12 bits
  localparam int SUM_W   = 12;
  localparam int ROUND   = 4;

  // floor(x / 9) as (x * 7282) >> 16, exact for x below 2304
  localparam int RECIP_W = 13;
  localparam logic [RECIP_W-1:0] RECIP9 = 13'd7282;
  localparam int RECIP_SH = 16;
  localparam int PROD_W  = SUM_W + RECIP_W;

  // Configuration port
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'd1;

  // Input operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Pipeline control from the top level to each channel lane
  typedef struct packed {
    logic en_b;      // sum stage takes the window
    logic en_c;      // result stage takes the sums
    logic interior;  // window center is an interior pixel
  } rbb_lane_ctl_t;

endpackage

/* hw/rtl/rbb_if.sv */
// Stream interfaces for input pixels and filtered output pixels.
interface rbb_in_if;
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [rbb_pkg::CH_W-1:0] red_in;
  logic [rbb_pkg::CH_W-1:0] green_in;
  logic [rbb_pkg::CH_W-1:0] blue_in;

  modport source (output valid, operation, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

interface rbb_out_if;
  logic                    valid;
  logic                    ready;
  logic [rbb_pkg::CH_W-1:0] red_out;
  logic [rbb_pkg::CH_W-1:0] green_out;
  logic [rbb_pkg::CH_W-1:0] blue_out;
  logic                    frame_end;

  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

/* hw/rtl/rbb_line_buf.sv */
// Two-row line buffer: one write port, one registered read port.
module rbb_line_buf #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [2*rbb_pkg::PX_W-1:0]   wdata,
  input  logic [AW-1:0]                raddr,
  output logic [2*rbb_pkg::PX_W-1:0]   rdata
);
  import rbb_pkg::*;

  logic [2*PX_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/rbb_lane.sv */
// One color channel lane: 3x3 sum, then rounded divide by nine, or the center tap on border pixels.
module rbb_lane (
  input  logic                         clk,
  input  rbb_pkg::rbb_lane_ctl_t       ctl,
  input  logic [rbb_pkg::CH_W-1:0]     taps [rbb_pkg::TAPS],
  output logic [rbb_pkg::CH_W-1:0]     result
);
  import rbb_pkg::*;

  logic [SUM_W-1:0]  sum_a;
  logic [SUM_W-1:0]  sum_b;
  logic [CH_W-1:0]   ctr_b;
  logic              int_b;
  logic [PROD_W-1:0] prod;

  // Adder tree over the nine window taps
  always_comb begin
    sum_a = '0;
    for (int i = 0; i < TAPS; i++) begin
      sum_a = sum_a + SUM_W'(taps[i]);
    end
  end

  // Sum stage: rounded sum, center tap for border passthrough
  always_ff @(posedge clk) begin
    if (ctl.en_b) begin
      sum_b <= sum_a + SUM_W'(ROUND);
      ctr_b <= taps[CENTER];
      int_b <= ctl.interior;
    end
  end

  // Divide by nine through the reciprocal
  assign prod = PROD_W'(sum_b) * PROD_W'(RECIP9);

  // Result stage
  always_ff @(posedge clk) begin
    if (ctl.en_c) begin
      result <= int_b ? prod[RECIP_SH +: CH_W] : ctr_b;
    end
  end

endmodule

/* hw/rtl/rgb_box_blur_3x3.sv */
// Streaming RGB 3x3 box blur: one pixel per clock, rounded mean on interior
// pixels, border rows and columns passed through. The block takes one beat
// per clock cycle whenever the output side is not stalled; in stream terms
// output pixel k comes out for input beat k + image_cols + 1, so each frame
// is drained by image_cols + 1 flush beats (pixel beats after the last pixel
// of a frame act as flushes). A flush beat sent before the frame's pixels are
// all in is taken and ignored. Full rate comes from the line buffer, which has
// a separate write port and registered read port (one read and one write per
// beat); the three-stage pipeline (window update, per-channel adder tree,
// reciprocal multiply) carries the beat that completes a window to its
// result. The three channels run in parallel lanes. The line buffer needs no
// clearing pass after reset.
// Writing image_cols or image_rows restarts the frame; write them only while
// no beat is in flight.
module rgb_box_blur_3x3 #(
  parameter int MAX_COLS = 2048,
  parameter int MAX_ROWS = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  rbb_in_if.sink                          pix_in,
  rbb_out_if.source                       pix_out,
  input  logic                            cfg_we,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbb_pkg::CFG_W-1:0]       cfg_data
);
  import rbb_pkg::*;

  localparam int AW = $clog2(MAX_COLS);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int RW = $clog2(MAX_ROWS + 2);
  localparam int COLS_RST = (2048 > MAX_COLS) ? MAX_COLS : 2048;
  localparam int ROWS_RST = (2048 > MAX_ROWS) ? MAX_ROWS : 2048;

  // Frame geometry and raster position
  logic [CW-1:0] cols;
  logic [RW-1:0] rows;
  logic [AW-1:0] ic, ic_next;
  logic [RW-1:0] ir, ir_next;

  // Pipeline valids and flags
  logic va, vb, vc;
  logic int_a, last_a, last_b, last_c;
  logic in_ready, en_b, en_c;

  // Per-beat decode
  logic          accept, advance, draining, due, interior, last, wrap;
  logic [CW-1:0] ic_plus;
  logic [PX_W-1:0] px;
  logic [31:0]   cfg_v32;
  logic [CW-1:0] cols_wr;
  logic [RW-1:0] rows_wr;

  // Line buffer and window
  logic [2*PX_W-1:0] lb_rd;
  logic [PX_W-1:0]   upper_rd, middle_rd;
  logic [PX_W-1:0]   win [3][3];

  rbb_lane_ctl_t    lane_ctl;
  logic [CH_W-1:0]  lane_taps [LANES][TAPS];
  logic [CH_W-1:0]  lane_res  [LANES];

  // Backpressure chain through the three stages
  assign en_c     = !vc || pix_out.ready;
  assign en_b     = !vb || en_c;
  assign in_ready = !va || en_b;
  assign pix_in.ready = in_ready;

  assign accept   = pix_in.valid && in_ready;
  assign draining = ir >= rows;
  assign advance  = accept && !(pix_in.operation == OP_FLUSH && !draining);

  assign due      = (ir >= RW'(2)) || (ir == RW'(1) && ic != '0);
  assign interior = (ic >= AW'(2)) && (ir >= RW'(2)) && !draining;
  assign last     = (ic == '0) && (ir == rows + RW'(1));

  assign ic_plus  = CW'(ic) + CW'(1);
  assign wrap     = ic_plus >= cols;
  assign px       = draining ? '0 : {pix_in.red_in, pix_in.green_in, pix_in.blue_in};

  // Clamp configuration writes into range
  assign cfg_v32 = 32'(cfg_data);
  always_comb begin
    if (cfg_v32 < 32'd3) begin
      cols_wr = CW'(3);
      rows_wr = RW'(3);
    end else begin
      cols_wr = (cfg_v32 > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cfg_data);
      rows_wr = (cfg_v32 > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(cfg_data);
    end
  end

  // Next raster position
  always_comb begin
    ic_next = ic;
    ir_next = ir;
    if (rst || cfg_we) begin
      ic_next = '0;
      ir_next = '0;
    end else if (advance) begin
      if (last) begin
        ic_next = '0;
        ir_next = '0;
      end else if (wrap) begin
        ic_next = '0;
        ir_next = ir + RW'(1);
      end else begin
        ic_next = AW'(ic_plus);
      end
    end
  end

  // Geometry registers and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= CW'(COLS_RST);
      rows <= RW'(ROWS_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_COLS: cols <= cols_wr;
        REG_IMAGE_ROWS: rows <= rows_wr;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ic <= ic_next;
    ir <= ir_next;
  end

  // Line buffer: read ahead at the next position, write back at this one
  rbb_line_buf #(
    .DEPTH (MAX_COLS),
    .AW    (AW)
  ) u_line_buf (
    .clk   (clk),
    .we    (advance),
    .waddr (ic),
    .wdata ({middle_rd, px}),
    .raddr (ic_next),
    .rdata (lb_rd)
  );

  assign upper_rd  = lb_rd[2*PX_W-1:PX_W];
  assign middle_rd = lb_rd[PX_W-1:0];

  // Window: shift left, new right column from the line buffer and input
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (advance) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= upper_rd;
      win[1][2] <= middle_rd;
      win[2][2] <= px;
    end
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (in_ready) va <= advance && due;
      if (en_b)     vb <= va;
      if (en_c)     vc <= vb;
    end
  end

  // Stage flags
  always_ff @(posedge clk) begin
    if (advance) begin
      int_a  <= interior;
      last_a <= last;
    end
    if (en_b) last_b <= last_a;
    if (en_c) last_c <= last_b;
  end

  // Channel lanes
  assign lane_ctl.en_b     = en_b;
  assign lane_ctl.en_c     = en_c;
  assign lane_ctl.interior = int_a;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    for (genvar t = 0; t < TAPS; t++) begin : g_tap
      assign lane_taps[l][t] = win[t / 3][t % 3][PX_W - CH_W*(l+1) +: CH_W];
    end

    rbb_lane u_lane (
      .clk    (clk),
      .ctl    (lane_ctl),
      .taps   (lane_taps[l]),
      .result (lane_res[l])
    );
  end

  // Merge lanes into the output beat
  assign pix_out.valid     = vc;
  assign pix_out.red_out   = lane_res[0];
  assign pix_out.green_out = lane_res[1];
  assign pix_out.blue_out  = lane_res[2];
  assign pix_out.frame_end = last_c;

endmodule

/* hw/rtl/rbb_checker.sv */
// Port-level checks for the box blur, bound to the top level.
module rbb_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rbb_pkg::CH_W-1:0]  red_out,
  input logic [rbb_pkg::CH_W-1:0]  green_out,
  input logic [rbb_pkg::CH_W-1:0]  blue_out,
  input logic                      frame_end
);
  import rbb_pkg::*;

  // A stalled output beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
      && $stable(blue_out) && $stable(frame_end))
    else $error("output beat changed while stalled");

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // With the output side open the block always takes a beat
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output ready");

endmodule

bind rgb_box_blur_3x3 rbb_checker u_rbb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .red_out   (pix_out.red_out),
  .green_out (pix_out.green_out),
  .blue_out  (pix_out.blue_out),
  .frame_end (pix_out.frame_end)
);
